@@ src/crc8bsf_pkg.sv @@
// shared types, constants and the crc-8 step function of the stuffing framer
`default_nettype none

package crc8bsf_pkg;

  // line control codes
  localparam logic [7:0] FlagByte = 8'h24;
  localparam logic [7:0] EscByte  = 8'h5C;
  localparam logic [7:0] EscXor   = 8'h20;

  // crc-8/atm
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcInit = 8'h00;

  // one input word can cause at most this many line bytes
  localparam int unsigned BurstDepth = 6;
  localparam int unsigned CntW       = $clog2(BurstDepth + 1);
  localparam int unsigned IdxW       = $clog2(BurstDepth);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       run_last;
  } out_word_t;

  // one queued line byte
  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } slot_t;

  // line bytes built for one input word, plus the framer state after it
  typedef struct packed {
    slot_t [BurstDepth-1:0] slots;
    logic [CntW-1:0]        cnt;
    logic                   in_frame;
    logic [7:0]             crc;
  } burst_t;

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FlagByte) || (b == EscByte);
  endfunction

endpackage

`default_nettype wire

@@ src/crc8bsf_burst.sv @@
// builds the stuffed line bytes and next framer state for one input word
`default_nettype none

module crc8bsf_burst import crc8bsf_pkg::*; (
  input  var in_word_t   word_i,
  input  var logic       in_frame_i,
  input  var logic [7:0] crc_i,
  output burst_t         burst_o
);

  logic [7:0]      crc_new;
  logic [IdxW-1:0] n;

  assign crc_new = crc8_update(in_frame_i ? crc_i : CrcInit, word_i.data_byte);

  // append bytes in line order
  always_comb begin
    burst_o = '0;
    n       = '0;
    // start flag when no frame is open
    if (!in_frame_i) begin
      burst_o.slots[n] = '{line_byte: FlagByte, frame_end: 1'b0};
      n = n + IdxW'(1);
    end
    // payload byte, stuffed
    if (needs_escape(word_i.data_byte)) begin
      burst_o.slots[n] = '{line_byte: EscByte, frame_end: 1'b0};
      n = n + IdxW'(1);
      burst_o.slots[n] = '{line_byte: word_i.data_byte ^ EscXor, frame_end: 1'b0};
    end else begin
      burst_o.slots[n] = '{line_byte: word_i.data_byte, frame_end: 1'b0};
    end
    // trailer: stuffed crc and closing flag
    if (word_i.last_byte) begin
      n = n + IdxW'(1);
      if (needs_escape(crc_new)) begin
        burst_o.slots[n] = '{line_byte: EscByte, frame_end: 1'b0};
        n = n + IdxW'(1);
        burst_o.slots[n] = '{line_byte: crc_new ^ EscXor, frame_end: 1'b0};
      end else begin
        burst_o.slots[n] = '{line_byte: crc_new, frame_end: 1'b0};
      end
      n = n + IdxW'(1);
      burst_o.slots[n] = '{line_byte: FlagByte, frame_end: 1'b1};
    end
    burst_o.cnt      = CntW'(n) + CntW'(1);
    burst_o.in_frame = !word_i.last_byte;
    burst_o.crc      = word_i.last_byte ? CrcInit : crc_new;
  end

endmodule

`default_nettype wire

@@ src/crc8_byte_stuffed_frame_encoder.sv @@
// Byte-stuffing frame encoder with a CRC-8/ATM trailer.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one payload byte per
// word, with last_byte set on the final byte of a frame. Output channel
// (out_valid_o/out_ready_i/out_data_o) gives the stuffed line stream one byte
// per word: the start flag before a frame, each payload byte (0x24 and 0x5C
// escaped), and after the last byte the escaped CRC and the closing flag,
// which carries frame_end. run_last marks the last line byte of each input.
//
// The first line byte of an accepted word is registered and valid the next cycle.
// An input word stays in the burst queue until all the line bytes it causes,
// one to six, have drained through the single output byte port.
// A new word is taken in the cycle the last byte of the previous one leaves.
// Reset clears the queue and closes any open frame, with the CRC at zero.
// When the receiver stalls the head byte holds and input is not taken while
// the queue holds any byte.
`default_nettype none

module crc8_byte_stuffed_frame_encoder import crc8bsf_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      in_valid_i,
  output logic          in_ready_o,
  input  var in_word_t  in_data_i,
  output logic          out_valid_o,
  input  var logic      out_ready_i,
  output out_word_t     out_data_o
);

  slot_t [BurstDepth-1:0] slots_q, slots_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   in_frame_q, in_frame_d;
  logic [7:0]             crc_q, crc_d;
  burst_t                 burst;
  logic                   pop, push;

  crc8bsf_burst u_burst (
    .word_i     (in_data_i),
    .in_frame_i (in_frame_q),
    .crc_i      (crc_q),
    .burst_o    (burst)
  );

  // handshakes
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign push        = in_valid_i && in_ready_o;

  // head of the queue drives the output word
  assign out_data_o = '{line_byte: slots_q[0].line_byte,
                        frame_end: slots_q[0].frame_end,
                        run_last:  (cnt_q == CntW'(1))};

  // queue load, shift and framer state
  always_comb begin
    slots_d    = slots_q;
    cnt_d      = cnt_q;
    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    if (push) begin
      slots_d    = burst.slots;
      cnt_d      = burst.cnt;
      in_frame_d = burst.in_frame;
      crc_d      = burst.crc;
    end else if (pop) begin
      for (int k = 0; k < BurstDepth - 1; k++) begin
        slots_d[k] = slots_q[k+1];
      end
      slots_d[BurstDepth-1] = '0;
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      in_frame_q <= 1'b0;
      crc_q      <= CrcInit;
    end else begin
      cnt_q      <= cnt_d;
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

endmodule

`default_nettype wire

@@ tb/tb_crc8_byte_stuffed_frame_encoder.sv @@
// testbench of the crc-8 byte stuffing framer: directed table, random frames, line-byte checks
`default_nettype none

module tb_crc8_byte_stuffed_frame_encoder import crc8bsf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // one directed input word, with line bytes typed in where they are obvious
  typedef struct packed {
    in_word_t         word;
    logic [2:0]       n_typed;
    out_word_t [5:0]  typed;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  // framer state as the encoder sees it
  logic      frame_open;
  logic [7:0] frame_crc;

  out_word_t line_scratch[$];
  out_word_t line_expected[$];
  stim_row_t dir_rows[$];

  int unsigned mismatches;
  int unsigned lines_seen;
  int unsigned stall_left;
  int unsigned words_sent;

  crc8_byte_stuffed_frame_encoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // crc-8/atm, one data bit at a time from the msb
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r  = {r[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return r;
  endfunction

  function automatic out_word_t ow(input logic [7:0] b, input logic fe, input logic rl);
    out_word_t w;
    w.line_byte = b;
    w.frame_end = fe;
    w.run_last  = rl;
    return w;
  endfunction

  function automatic void push_line(input logic [7:0] b, input logic fe);
    line_scratch.push_back(ow(b, fe, 1'b0));
  endfunction

  function automatic void push_stuffed(input logic [7:0] b);
    if (b == FlagByte || b == EscByte) begin
      push_line(EscByte, 1'b0);
      push_line(b ^ EscXor, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  // line bytes caused by one word, and the framer state after it
  function automatic void encode_word(input in_word_t w);
    out_word_t tail;
    line_scratch.delete();
    if (!frame_open) begin
      push_line(FlagByte, 1'b0);
      frame_open = 1'b1;
      frame_crc  = CrcInit;
    end
    frame_crc = crc8_step(frame_crc, w.data_byte);
    push_stuffed(w.data_byte);
    if (w.last_byte) begin
      push_stuffed(frame_crc);
      push_line(FlagByte, 1'b1);
      frame_open = 1'b0;
      frame_crc  = CrcInit;
    end
    tail = line_scratch.pop_back();
    tail.run_last = 1'b1;
    line_scratch.push_back(tail);
  endfunction

  // payload byte whose single-byte crc is the given value
  function automatic logic [7:0] byte_for_crc(input logic [7:0] target);
    logic [7:0] found;
    found = 8'h00;
    for (int b = 0; b < 256; b++) begin
      if (crc8_step(CrcInit, b[7:0]) == target) found = b[7:0];
    end
    return found;
  endfunction

  function automatic stim_row_t mk_row(input logic [7:0] data, input logic last);
    stim_row_t r;
    r = '0;
    r.word.data_byte = data;
    r.word.last_byte = last;
    return r;
  endfunction

  // drive one word after the given idle gap, and queue its line bytes on acceptance
  task automatic send_row(input stim_row_t row, input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= row.word;
    do @(posedge clk); while (!in_ready);
    encode_word(row.word);
    if (row.n_typed != 0) begin
      for (int i = 0; i < row.n_typed; i++) line_expected.push_back(row.typed[i]);
    end else begin
      foreach (line_scratch[i]) line_expected.push_back(line_scratch[i]);
    end
    words_sent++;
  endtask

  // hold the sender off until every queued line byte has come out
  task automatic drain_lines();
    @(negedge clk);
    in_valid <= 1'b0;
    while (line_expected.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned sender_gap();
    if ((words_sent / 32) % 3 == 2) return 0;
    return $urandom_range(0, 6);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // line byte checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (line_expected.size() == 0) begin
        if (mismatches < 10) $display("unexpected line word %h", out_word);
        mismatches++;
      end else begin
        out_word_t exp_w;
        exp_w = line_expected.pop_front();
        if (exp_w.line_byte !== out_word.line_byte || exp_w.frame_end !== out_word.frame_end
            || exp_w.run_last !== out_word.run_last) begin
          if (mismatches < 10) begin
            $display({"line word mismatch: expected byte %h end %b last %b, ",
                      "got byte %h end %b last %b"},
                     exp_w.line_byte, exp_w.frame_end, exp_w.run_last,
                     out_word.line_byte, out_word.frame_end, out_word.run_last);
          end
          mismatches++;
        end
      end
      lines_seen++;
      stall_left = ((lines_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 6);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_crc8_byte_stuffed_frame_encoder: FAIL");
    $finish;
  end

  initial begin
    stim_row_t   r;
    int unsigned flen;
    int unsigned pick;
    logic [7:0]  d;

    in_valid   = 1'b0;
    in_word    = '0;
    out_ready  = 1'b0;
    rst_n      = 1'b0;
    frame_open = 1'b0;
    frame_crc  = CrcInit;
    mismatches = 0;
    lines_seen = 0;
    stall_left = 0;
    words_sent = 0;

    // directed rows: open and close a zero frame, escapes, single-byte frames
    r = mk_row(8'h00, 1'b0);
    r.n_typed = 2;
    r.typed[0] = ow(FlagByte, 1'b0, 1'b0);
    r.typed[1] = ow(8'h00, 1'b0, 1'b1);
    dir_rows.push_back(r);
    r = mk_row(8'h00, 1'b1);
    r.n_typed = 3;
    r.typed[0] = ow(8'h00, 1'b0, 1'b0);
    r.typed[1] = ow(8'h00, 1'b0, 1'b0);
    r.typed[2] = ow(FlagByte, 1'b1, 1'b1);
    dir_rows.push_back(r);
    r = mk_row(EscByte, 1'b0);
    r.n_typed = 3;
    r.typed[0] = ow(FlagByte, 1'b0, 1'b0);
    r.typed[1] = ow(EscByte, 1'b0, 1'b0);
    r.typed[2] = ow(8'h7C, 1'b0, 1'b1);
    dir_rows.push_back(r);
    r = mk_row(FlagByte, 1'b0);
    r.n_typed = 2;
    r.typed[0] = ow(EscByte, 1'b0, 1'b0);
    r.typed[1] = ow(8'h04, 1'b0, 1'b1);
    dir_rows.push_back(r);
    dir_rows.push_back(mk_row(8'hFF, 1'b0));
    dir_rows.push_back(mk_row(8'h80, 1'b0));
    dir_rows.push_back(mk_row(8'h01, 1'b1));
    dir_rows.push_back(mk_row(8'hFF, 1'b1));
    dir_rows.push_back(mk_row(FlagByte, 1'b1));
    dir_rows.push_back(mk_row(EscByte, 1'b1));
    // crc that itself needs escaping
    dir_rows.push_back(mk_row(byte_for_crc(FlagByte), 1'b1));
    dir_rows.push_back(mk_row(byte_for_crc(EscByte), 1'b1));
    // near misses of the control bytes
    dir_rows.push_back(mk_row(8'h7C, 1'b0));
    dir_rows.push_back(mk_row(8'h04, 1'b0));
    dir_rows.push_back(mk_row(8'h5B, 1'b0));
    dir_rows.push_back(mk_row(8'h25, 1'b0));
    dir_rows.push_back(mk_row(8'h23, 1'b1));
    dir_rows.push_back(mk_row(8'hAA, 1'b0));
    dir_rows.push_back(mk_row(8'h55, 1'b1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_row(dir_rows[i], sender_gap());
    drain_lines();

    // random frames, mostly short, with control bytes favored
    while (words_sent < 310) begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      for (int i = 0; i < flen; i++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) d = FlagByte;
        else if (pick == 1) d = EscByte;
        else d = 8'($urandom_range(0, 255));
        send_row(mk_row(d, i == flen - 1), sender_gap());
      end
      if ($urandom_range(0, 15) == 0) drain_lines();
    end

    drain_lines();
    repeat (20) @(posedge clk);
    if (line_expected.size() != 0) begin
      $display("%0d line words never arrived", line_expected.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_crc8_byte_stuffed_frame_encoder: PASS");
    end else begin
      $display("tb_crc8_byte_stuffed_frame_encoder: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
